// ===== sv/mnls_pkg.sv =====
// ----------------------------------------------------------------------------
// mnls_pkg
// Types, constants and control-store codes for the adaptive threshold neuron
// log-likelihood step core.
// ----------------------------------------------------------------------------
package mnls_pkg;

  localparam int NUM_CFG = 8;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam logic [31:0] DT_RESET = 32'd65536;
  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

  localparam logic [CFG_IDX_W-1:0] REG_VOLT_COEFS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VTHR_VOLT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VTHR_SELF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VRATE_VOLT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_DECAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_JUMP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_GAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd7;

  typedef struct packed {
    logic signed [31:0] current_sample;
    logic spike_seen;
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] log_likelihood;
    logic signed [31:0] intensity_arg;
    logic halted;
  } out_item_t;

  // multiplier A-operand source
  typedef enum logic [2:0] {
    A_V, A_C, A_T, A_R, A_FAST, A_SLOW, A_DCUR
  } asel_t;

  // accumulator action
  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD
  } acc_t;

  // write-back target
  typedef enum logic [2:0] {
    WB_NONE, WB_V, WB_T, WB_R, WB_C, WB_FAST, WB_SLOW
  } wb_t;

  typedef struct packed {
    asel_t a_sel;
    logic [CFG_IDX_W-1:0] b_reg;
    logic b_hi;
    acc_t acc;
    wb_t wb;
    logic last;
  } uop_t;

  localparam int PROG_LEN = 12;
  localparam int PC_W = 4;

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{A_V, REG_VOLT_COEFS, 1'b0, ACC_NONE, WB_NONE, 1'b0};
    unique case (pc)
      4'd0: u = '{A_V, REG_VTHR_VOLT, 1'b0, ACC_LOAD, WB_NONE, 1'b0};
      4'd1: u = '{A_C, REG_VTHR_VOLT, 1'b1, ACC_ADD, WB_NONE, 1'b0};
      4'd2: u = '{A_T, REG_VTHR_SELF, 1'b0, ACC_ADD, WB_NONE, 1'b0};
      4'd3: u = '{A_R, REG_VTHR_SELF, 1'b1, ACC_ADD, WB_T, 1'b0};
      4'd4: u = '{A_V, REG_VRATE_VOLT, 1'b0, ACC_LOAD, WB_NONE, 1'b0};
      4'd5: u = '{A_C, REG_VRATE_VOLT, 1'b1, ACC_ADD, WB_NONE, 1'b0};
      4'd6: u = '{A_R, REG_VTHR_SELF, 1'b0, ACC_ADD, WB_R, 1'b0};
      4'd7: u = '{A_V, REG_VOLT_COEFS, 1'b0, ACC_LOAD, WB_NONE, 1'b0};
      4'd8: u = '{A_C, REG_VOLT_COEFS, 1'b1, ACC_ADD, WB_V, 1'b0};
      4'd9: u = '{A_DCUR, REG_OFFSET_GAIN, 1'b1, ACC_ADD, WB_C, 1'b0};
      4'd10: u = '{A_FAST, REG_HIST_DECAY, 1'b0, ACC_LOAD, WB_FAST, 1'b0};
      4'd11: u = '{A_SLOW, REG_HIST_DECAY, 1'b1, ACC_LOAD, WB_SLOW, 1'b1};
      default: u = '{A_V, REG_VOLT_COEFS, 1'b0, ACC_NONE, WB_NONE, 1'b1};
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  typedef enum logic [3:0] {
    S_IDLE, S_PROP, S_MU, S_EXP_Y, S_EXP_P1, S_EXP_P2, S_EXP_P3, S_EXP_P4,
    S_EXP_DT, S_EXP_SH, S_SUM, S_DONE
  } state_t;

endpackage

// ===== sv/mat_neuron_loglik_step_core.sv =====
// ----------------------------------------------------------------------------
// mat_neuron_loglik_step_core
// From item accept to result valid: 12 microcode steps on one shared 33x32
// multiplier, then mu, 7 exponential steps, the sum and the result load; a
// halted item skips the exponential steps and the sum. Items are taken only
// in idle, after the last result loads; a stalled result holds the sequencer
// in its last step. Reset clears state and loads dt = 1.0; no clearing pass.
// ----------------------------------------------------------------------------
module mat_neuron_loglik_step_core
  import mnls_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_value
);
  logic [CFG_W-1:0] cfg [NUM_CFG];
  state_t state, state_next;
  logic [PC_W-1:0] pc;
  uop_t uop;
  logic signed [31:0] v, c, t, r, fth, sth, prev;
  logic signed [32:0] dcur;
  logic signed [63:0] sum;
  logic halt, spk;
  logic signed [49:0] acc;
  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic signed [64:0] mp;
  logic signed [49:0] mr;
  logic signed [31:0] mu;
  logic signed [63:0] y;
  logic [17:0] p;
  logic [48:0] prod;
  logic [63:0] term;
  logic t_ovf, x_ovf;
  logic signed [64:0] d, ns;
  logic accept;
  logic out_free;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    uop = ucode(pc);
    unique case (uop.a_sel)
      A_V: ma = 33'(v);
      A_C: ma = 33'(c);
      A_T: ma = 33'(t);
      A_R: ma = 33'(r);
      A_FAST: ma = 33'(fth);
      A_SLOW: ma = 33'(sth);
      A_DCUR: ma = dcur;
      default: ma = 33'(v);
    endcase
    mb = uop.b_hi ? cfg[uop.b_reg][63:32] : cfg[uop.b_reg][31:0];
    mp = ma * mb + 65'sd32768;
    mr = 50'(mp >>> 16);
  end

  mnls_exp_shift u_sh (.prod(prod), .k(18'(y >>> 46)), .term(term), .ovf(x_ovf));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_PROP;
      S_PROP: if (uop.last) state_next = S_MU;
      S_MU: state_next = halt ? S_DONE : S_EXP_Y;
      S_EXP_Y: state_next = S_EXP_P1;
      S_EXP_P1: state_next = S_EXP_P2;
      S_EXP_P2: state_next = S_EXP_P3;
      S_EXP_P3: state_next = S_EXP_P4;
      S_EXP_P4: state_next = S_EXP_DT;
      S_EXP_DT: state_next = S_EXP_SH;
      S_EXP_SH: state_next = S_SUM;
      S_SUM: state_next = S_DONE;
      S_DONE: state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    d = 65'(spk ? 64'(mu) : 64'sd0) - $signed({1'b0, term});
    ns = 65'(sum) + d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      out_data <= '0;
      pc <= '0;
      for (int i = 0; i < NUM_CFG; i++)
        cfg[i] <= (i == int'(REG_TIME_STEP)) ? 64'(DT_RESET) : '0;
      {v, c, t, r, fth, sth, prev} <= '0;
      sum <= '0;
      halt <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cfg[cfg_index] <= (cfg_index == REG_TIME_STEP) ? {32'd0, cfg_value[31:0]}
                                                        : cfg_value;
      end
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          pc <= (accept && halt && !in_data.restart) ? PC_W'(PROG_LEN) : '0;
          if (accept) begin
            spk <= in_data.spike_seen;
            dcur <= 33'(in_data.current_sample) - 33'(in_data.restart ? 32'sd0 : prev);
            if (in_data.restart || !halt) prev <= in_data.current_sample;
            if (in_data.restart) begin
              {v, c, t, r, fth, sth} <= '0;
              sum <= '0;
              halt <= 1'b0;
            end
          end
        end
        S_PROP: begin
          pc <= pc + 1'b1;
          if (uop.acc == ACC_LOAD) acc <= mr;
          else acc <= acc + mr;
          unique case (uop.wb)
            WB_V: v <= sat32(acc + mr);
            WB_T: t <= sat32(acc + mr);
            WB_R: r <= sat32(acc + mr);
            WB_C: c <= sat32(50'(c) + mr);
            WB_FAST: fth <= sat32(mr);
            WB_SLOW: sth <= sat32(mr);
            default: ;
          endcase
        end
        S_MU: begin
          mu <= halt ? 32'sd0 : sat32(50'(v) - 50'(t) - 50'(fth) - 50'(sth)
                                    - 50'($signed(cfg[REG_OFFSET_GAIN][31:0])));
        end
        S_EXP_Y: begin
          y <= 64'(mu) * 64'(LOG2E_Q30);
          p <= 18'd630;
        end
        S_EXP_P1: p <= 18'd3638 + 18'((36'(p) * 36'(y[45:30])) >> 16);
        S_EXP_P2: p <= 18'd15743 + 18'((36'(p) * 36'(y[45:30])) >> 16);
        S_EXP_P3: p <= 18'd45426 + 18'((36'(p) * 36'(y[45:30])) >> 16);
        S_EXP_P4: p <= 18'd65536 + 18'((36'(p) * 36'(y[45:30])) >> 16);
        S_EXP_DT: prod <= 49'(cfg[REG_TIME_STEP][31:0]) * 49'(p);
        S_EXP_SH: t_ovf <= x_ovf;
        S_SUM: begin
          if (t_ovf) begin
            sum <= 64'sh8000000000000000;
            halt <= 1'b1;
          end else if (ns > 65'sh0_7fffffffffffffff) begin
            sum <= 64'sh7fffffffffffffff;
            halt <= 1'b1;
          end else if (ns < -65'sh0_8000000000000000) begin
            sum <= 64'sh8000000000000000;
            halt <= 1'b1;
          end else begin
            sum <= ns[63:0];
            if (spk) begin
              fth <= sat32(50'(fth) + 50'($signed(cfg[REG_HIST_JUMP][31:0])));
              sth <= sat32(50'(sth) + 50'($signed(cfg[REG_HIST_JUMP][63:32])));
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data.log_likelihood <= sum;
            out_data.intensity_arg <= mu;
            out_data.halted <= halt;
          end
        end
        default: ;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data)) else $error("result changed while held");

endmodule

// ===== sv/mnls_exp_shift.sv =====
// ----------------------------------------------------------------------------
// mnls_exp_shift
// Scales dt*2^frac by 2^(k-16) and checks the term limit.
// ----------------------------------------------------------------------------
module mnls_exp_shift
  import mnls_pkg::*;
(
  input  logic [48:0] prod,
  input  logic signed [17:0] k,
  output logic [63:0] term,
  output logic ovf
);
  logic signed [18:0] sh;
  logic [63:0] limit;
  logic [111:0] wide;

  always_comb begin
    sh = 19'(k) - 19'sd16;
    limit = 64'd1 << 62;
    term = '0;
    ovf = 1'b0;
    wide = '0;
    if (prod == '0) begin
      term = '0;
    end else if (sh >= 0) begin
      if (sh >= 19'sd62) begin
        ovf = 1'b1;
      end else begin
        wide = {63'd0, prod} << sh[5:0];
        if (wide > {48'd0, limit}) ovf = 1'b1;
        else term = wide[63:0];
      end
    end else begin
      if (sh <= -19'sd64) term = '0;
      else term = {15'd0, prod} >> 6'(-sh);
    end
  end
endmodule
